/* hw/rtl/sds_pkg.sv */
// Shared types and constants for the SCAN disk scheduler.
// No dependencies; compile first.
package sds_pkg;

  localparam int MAX_REQ = 32;
  localparam int CYL_W   = 16;
  localparam int CNT_W   = $clog2(MAX_REQ + 1);
  localparam int SEEK_W  = 22;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP  = 1'd1;

  localparam logic [CFG_W-1:0]  TOP_RESET = 16'd199;
  localparam logic [SEEK_W-1:0] SEEK_MAX  = {SEEK_W{1'b1}};

  // Per-cycle command to every cell of a chain.
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    cell_ctl_t op;
    logic      clear;
  } chain_ctl_t;

  // What a cell shows its right-hand neighbor.
  typedef struct packed {
    logic             gt;
    logic             occ;
    logic [CYL_W-1:0] data;
  } cell_link_t;

  typedef enum logic [5:0] {
    ST_COLLECT = 6'b000001,
    ST_UPPER   = 6'b000010,
    ST_TOP     = 6'b000100,
    ST_LOWER   = 6'b001000,
    ST_ZERO    = 6'b010000,
    ST_FINAL   = 6'b100000
  } sds_state_t;

endpackage

/* hw/rtl/sds_req_if.sv */
// Request channel: one cylinder per beat, last beat of the batch flagged.
// Depends on sds_pkg.
interface sds_req_if;
  import sds_pkg::*;
  logic             valid;
  logic             ready;
  logic [CYL_W-1:0] cylinder;
  logic             last_request;

  modport source (output valid, output cylinder, output last_request, input ready);
  modport sink   (input valid, input cylinder, input last_request, output ready);
endinterface

/* hw/rtl/sds_res_if.sv */
// Result channel: one visited cylinder of the service path per beat.
// Depends on sds_pkg.
interface sds_res_if;
  import sds_pkg::*;
  logic              valid;
  logic              ready;
  logic [CYL_W-1:0]  position;
  logic [15:0]       step_distance;
  logic [SEEK_W-1:0] total_seek;
  logic              overflow;
  logic              path_end;

  modport source (output valid, output position, output step_distance,
                  output total_seek, output overflow, output path_end, input ready);
  modport sink   (input valid, input position, input step_distance,
                  input total_seek, input overflow, input path_end, output ready);
endinterface

/* hw/rtl/sds_cell.sv */
// One cell of a sorted insertion chain: holds one cylinder.
// Depends on sds_pkg.
module sds_cell (
  input  logic                    clk,
  input  sds_pkg::cell_ctl_t      ctl,
  input  logic                    desc,
  input  logic [sds_pkg::CYL_W-1:0] v,
  input  logic                    occ,
  input  sds_pkg::cell_link_t     left,
  input  logic [sds_pkg::CYL_W-1:0] right_data,
  output sds_pkg::cell_link_t     link
);
  import sds_pkg::*;

  logic [CYL_W-1:0] data;
  logic             gt;

  // gt: the new value belongs at or before this cell
  assign gt   = occ && (desc ? (data < v) : (data > v));
  assign link = '{gt: gt, occ: occ, data: data};

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left.gt) begin
        data <= left.data;
      end else if (gt || (!occ && left.occ)) begin
        data <= v;
      end
    end else if (ctl.shift) begin
      data <= right_data;
    end
  end

endmodule

/* hw/rtl/sds_chain.sv */
// Row of sds_cell plus its fill count; sorted insert, shift-out at cell 0.
// Depends on sds_pkg, sds_cell.
module sds_chain (
  input  logic                      clk,
  input  logic                      rst,
  input  sds_pkg::chain_ctl_t       ctl,
  input  logic                      desc,
  input  logic [sds_pkg::CYL_W-1:0] v,
  output logic [sds_pkg::CYL_W-1:0] first,
  output logic [sds_pkg::CNT_W-1:0] count
);
  import sds_pkg::*;

  cell_link_t links [MAX_REQ];

  for (genvar i = 0; i < MAX_REQ; i++) begin : g_cell
    cell_link_t       left;
    logic [CYL_W-1:0] right_data;
    logic             occ;

    assign occ = (count > CNT_W'(i));
    if (i == 0) begin : g_first
      assign left = '{gt: 1'b0, occ: 1'b1, data: v};
    end else begin : g_mid
      assign left = links[i-1];
    end
    if (i == MAX_REQ - 1) begin : g_last
      assign right_data = links[i].data;
    end else begin : g_inner
      assign right_data = links[i+1].data;
    end

    sds_cell u_cell (
      .clk        (clk),
      .ctl        (ctl.op),
      .desc       (desc),
      .v          (v),
      .occ        (occ),
      .left       (left),
      .right_data (right_data),
      .link       (links[i])
    );
  end

  assign first = links[0].data;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count <= '0;
    end else if (ctl.op.ins) begin
      count <= count + CNT_W'(1);
    end else if (ctl.op.shift) begin
      count <= count - CNT_W'(1);
    end
  end

endmodule

/* hw/rtl/scan_disk_scheduler.sv */
// SCAN (elevator) disk scheduler. Requests arrive one per beat on req and
// are taken one per cycle while the block collects a batch: each goes into
// one of two chains of cells, lower (at or below head_position, kept
// descending) or upper (above it, kept ascending), by a sorted insert that
// finishes in the cycle of the beat. Once 32 requests are held, further ones
// are dropped and the path is marked with overflow. The beat with
// last_request set closes the batch; req then stays not ready while res
// delivers the path: head, upper requests ascending, top_cylinder, lower
// requests descending, cylinder 0 (path_end). Each result carries the
// distance to the next cylinder and the seek total so far (saturating at 22
// bits). Results leave at one per cycle while res is ready, save where an
// empty chain is skipped, as the chains shift their front cell out; a batch
// holding n requests gives n+3 results, and req is ready again as soon as
// the last of them (path_end) is presented on res. Write configuration only
// while no batch is being emitted.
// Depends on sds_pkg, sds_req_if, sds_res_if, sds_chain.
module scan_disk_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sds_pkg::CFG_W-1:0]     cfg_data,
  sds_req_if.sink                       req,
  sds_res_if.source                     res
);
  import sds_pkg::*;

  logic [CYL_W-1:0] head_position;
  logic [CYL_W-1:0] top_cylinder;

  sds_state_t state, state_next;
  logic             dropped;
  logic [CYL_W-1:0] prev;
  logic [SEEK_W-1:0] total;

  chain_ctl_t       lo_ctl, up_ctl;
  logic [CYL_W-1:0] lo_first, up_first;
  logic [CNT_W-1:0] lo_cnt, up_cnt;

  logic             accept;
  logic             full;
  logic             to_lower;
  logic             load;
  logic             emit;
  logic             emit_end;
  logic [CYL_W-1:0] nv;
  logic [CYL_W-1:0] diff;
  logic [SEEK_W:0]  sum;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_position <= '0;
      top_cylinder  <= TOP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HEAD: head_position <= cfg_data;
        CFG_TOP:  top_cylinder  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Collect side
  assign req.ready = (state == ST_COLLECT);
  assign accept    = req.valid && req.ready;
  assign full      = ({1'b0, lo_cnt} + {1'b0, up_cnt}) >= (CNT_W + 1)'(MAX_REQ);
  assign to_lower  = (req.cylinder <= head_position);

  // Emit side: the output register frees up when empty or taken
  assign load = !res.valid || res.ready;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_end   = 1'b0;
    nv         = '0;
    lo_ctl     = '0;
    up_ctl     = '0;

    if (accept && !full) begin
      lo_ctl.op.ins = to_lower;
      up_ctl.op.ins = !to_lower;
    end

    case (state)
      ST_COLLECT: begin
        if (accept && req.last_request) begin
          state_next = ST_UPPER;
        end
      end
      ST_UPPER: begin
        if (up_cnt == '0) begin
          state_next = ST_TOP;
        end else if (load) begin
          emit = 1'b1;
          nv   = up_first;
          up_ctl.op.shift = 1'b1;
          if (up_cnt == CNT_W'(1)) begin
            state_next = ST_TOP;
          end
        end
      end
      ST_TOP: begin
        if (load) begin
          emit       = 1'b1;
          nv         = top_cylinder;
          state_next = ST_LOWER;
        end
      end
      ST_LOWER: begin
        if (lo_cnt == '0) begin
          state_next = ST_ZERO;
        end else if (load) begin
          emit = 1'b1;
          nv   = lo_first;
          lo_ctl.op.shift = 1'b1;
          if (lo_cnt == CNT_W'(1)) begin
            state_next = ST_ZERO;
          end
        end
      end
      ST_ZERO: begin
        if (load) begin
          emit       = 1'b1;
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (load) begin
          emit_end     = 1'b1;
          lo_ctl.clear = 1'b1;
          up_ctl.clear = 1'b1;
          state_next   = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // Step to the next cylinder and the saturating running total
  assign diff = (prev >= nv) ? (prev - nv) : (nv - prev);
  assign sum  = {1'b0, total} + (SEEK_W + 1)'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_COLLECT;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_end) begin
        dropped <= 1'b0;
      end else if (accept && full) begin
        dropped <= 1'b1;
      end
    end
  end

  // Path position and seek total; start at the head when the batch closes
  always_ff @(posedge clk) begin
    if (accept && req.last_request) begin
      prev  <= head_position;
      total <= '0;
    end else if (emit) begin
      prev  <= nv;
      total <= sum[SEEK_W] ? SEEK_MAX : sum[SEEK_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit || emit_end) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit || emit_end) begin
      res.position      <= prev;
      res.step_distance <= emit_end ? '0 : diff;
      res.total_seek    <= total;
      res.overflow      <= dropped;
      res.path_end      <= emit_end;
    end
  end

  sds_chain u_lower (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lo_ctl),
    .desc  (1'b1),
    .v     (req.cylinder),
    .first (lo_first),
    .count (lo_cnt)
  );

  sds_chain u_upper (
    .clk   (clk),
    .rst   (rst),
    .ctl   (up_ctl),
    .desc  (1'b0),
    .v     (req.cylinder),
    .first (up_first),
    .count (up_cnt)
  );

endmodule
